// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers shared by the meter modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/plm_pkg.sv
// ----------------------------------------------------------------------------
// plm_pkg
// types, codes and helper functions shared by the peak level meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plm_pkg;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int QUEUE_DEPTH      = 2;
  localparam int PEAK_W           = 33;
  localparam int COUNT_W          = 5;
  localparam int CFG_INDEX_W      = 2;
  localparam int CFG_DATA_W       = 4;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_FORMAT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;

  // sample format codes
  localparam logic [2:0] FMT_S8  = 3'd0;
  localparam logic [2:0] FMT_S16 = 3'd1;
  localparam logic [2:0] FMT_S32 = 3'd2;
  localparam logic [2:0] FMT_U8  = 3'd3;
  localparam logic [2:0] FMT_U16 = 3'd4;
  localparam logic [2:0] FMT_U32 = 3'd5;

  localparam logic [2:0] FMT_RESET   = FMT_S16;
  localparam logic [3:0] COUNT_RESET = 4'd2;

  typedef struct packed {
    logic [31:0] sample;
    logic        last_in_buffer;
  } sample_word_t;

  typedef struct packed {
    logic [2:0]         channel;
    logic signed [15:0] level;
    logic               last_level;
  } level_word_t;

  // control part of one buffer snapshot
  typedef struct packed {
    logic               valid;
    logic [2:0]         fmt;
    logic [COUNT_W-1:0] count;
  } snap_ctrl_t;

  // bit count k of the format, full scale is 2^k - 1
  function automatic logic [5:0] fmt_bits(input logic [2:0] fmt);
    logic [5:0] k;
    case (fmt)
      FMT_S8:  k = 6'd7;
      FMT_S16: k = 6'd15;
      FMT_S32: k = 6'd31;
      FMT_U8:  k = 6'd8;
      FMT_U16: k = 6'd16;
      default: k = 6'd32;
    endcase
    return k;
  endfunction

  function automatic logic fmt_signed(input logic [2:0] fmt);
    return fmt inside {FMT_S8, FMT_S16, FMT_S32};
  endfunction

  function automatic logic fmt_known(input logic [2:0] fmt);
    return fmt inside {[FMT_S8:FMT_U32]};
  endfunction

  function automatic logic [PEAK_W-1:0] fmt_max(input logic [2:0] fmt);
    return (PEAK_W'(1) << fmt_bits(fmt)) - PEAK_W'(1);
  endfunction

  // raw bits to a 33-bit two's complement value
  function automatic logic [PEAK_W-1:0] decode_sample(input logic [2:0] fmt,
                                                     input logic [31:0] raw);
    logic [PEAK_W-1:0] v;
    case (fmt)
      FMT_S8:  v = {{25{raw[7]}}, raw[7:0]};
      FMT_S16: v = {{17{raw[15]}}, raw[15:0]};
      FMT_S32: v = {raw[31], raw};
      FMT_U8:  v = {25'd0, raw[7:0]};
      FMT_U16: v = {17'd0, raw[15:0]};
      default: v = {1'b0, raw};
    endcase
    return v;
  endfunction

  function automatic logic [PEAK_W-1:0] magnitude(input logic [PEAK_W-1:0] v);
    return v[PEAK_W-1] ? -v : v;
  endfunction

endpackage

`default_nettype wire

// File: design/plm_front.sv
// ----------------------------------------------------------------------------
// plm_front
// config registers, sample decode, channel rotation and peak tracking
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plm_front #(
  parameter int MAX_CHANNELS = plm_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [plm_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [plm_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic                                  sample_valid,
  output logic                                       sample_stall,
  input  wire plm_pkg::sample_word_t                 sample_word,
  input  wire logic                                  q_full,
  output plm_pkg::snap_ctrl_t                        push_ctrl,
  output logic [MAX_CHANNELS-1:0][plm_pkg::PEAK_W-1:0] push_peaks
);

  localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW = plm_pkg::COUNT_W;
  localparam int PW = plm_pkg::PEAK_W;

  logic [2:0]                    fmt;
  logic [3:0]                    count;
  logic [IW-1:0]                 cursor;
  logic [MAX_CHANNELS-1:0][PW-1:0] peak;

  logic                          accept;
  logic [PW-1:0]                 value;
  logic                          take;
  logic [CW-1:0]                 active;
  logic [CW-1:0]                 cursor_inc;

  assign sample_stall = q_full;
  assign accept       = sample_valid && !q_full;

  assign value = plm_pkg::decode_sample(fmt, sample_word.sample);
  assign take  = plm_pkg::magnitude(value) > plm_pkg::magnitude(peak[cursor]);

  // zero counts as one, anything above the array size is clipped
  always_comb begin
    if (count == 4'd0) begin
      active = CW'(1);
    end else if ({1'b0, count} > CW'(MAX_CHANNELS)) begin
      active = CW'(MAX_CHANNELS);
    end else begin
      active = CW'(count);
    end
  end

  assign cursor_inc = CW'(cursor) + CW'(1);

  always_comb begin
    push_peaks = peak;
    if (take) begin
      push_peaks[cursor] = value;
    end
  end

  always_comb begin
    push_ctrl.valid = accept && sample_word.last_in_buffer;
    push_ctrl.fmt   = fmt;
    push_ctrl.count = active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt   <= plm_pkg::FMT_RESET;
      count <= plm_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        plm_pkg::CFG_SAMPLE_FORMAT: fmt   <= cfg_data[2:0];
        plm_pkg::CFG_CHANNEL_COUNT: count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      peak   <= '0;
    end else if (accept) begin
      if (sample_word.last_in_buffer) begin
        cursor <= '0;
        peak   <= '0;
      end else begin
        peak   <= push_peaks;
        cursor <= (cursor_inc >= active) ? '0 : IW'(cursor_inc);
      end
    end
  end

endmodule

`default_nettype wire

// File: design/plm_queue.sv
// ----------------------------------------------------------------------------
// plm_queue
// short queue of buffer snapshots between the front and the level unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module plm_queue #(
  parameter int MAX_CHANNELS = plm_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire plm_pkg::snap_ctrl_t                     push_ctrl,
  input  wire logic [MAX_CHANNELS-1:0][plm_pkg::PEAK_W-1:0] push_peaks,
  output logic                                         full,
  output plm_pkg::snap_ctrl_t                          head_ctrl,
  output logic [MAX_CHANNELS-1:0][plm_pkg::PEAK_W-1:0] head_peaks,
  input  wire logic                                    pop
);

  localparam int DEPTH = plm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PW    = plm_pkg::PEAK_W;

  logic [MAX_CHANNELS-1:0][PW-1:0] mem_peaks [DEPTH];
  logic [2:0]                      mem_fmt   [DEPTH];
  logic [plm_pkg::COUNT_W-1:0]     mem_count [DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full = (fill == CNT_W'(DEPTH));

  always_comb begin
    head_ctrl.valid = (fill != '0);
    head_ctrl.fmt   = mem_fmt[rd_ptr];
    head_ctrl.count = mem_count[rd_ptr];
    head_peaks      = mem_peaks[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push_ctrl.valid) begin
      mem_peaks[wr_ptr] <= push_peaks;
      mem_fmt[wr_ptr]   <= push_ctrl.fmt;
      mem_count[wr_ptr] <= push_ctrl.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push_ctrl.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push_ctrl.valid, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_push_when_full, clk, rst, push_ctrl.valid, !full, "snapshot pushed into full queue")
  `ASSERT_IMPL(a_no_pop_when_empty, clk, rst, pop, head_ctrl.valid, "snapshot popped from empty queue")

endmodule

`default_nettype wire

// File: design/plm_back.sv
// ----------------------------------------------------------------------------
// plm_back
// walks the channels of a snapshot and turns each peak into a q1.15 level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module plm_back #(
  parameter int MAX_CHANNELS = plm_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire plm_pkg::snap_ctrl_t                     head_ctrl,
  input  wire logic [MAX_CHANNELS-1:0][plm_pkg::PEAK_W-1:0] head_peaks,
  output logic                                         pop,
  output logic                                         level_valid,
  input  wire logic                                    level_stall,
  output plm_pkg::level_word_t                         level_word
);

  localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW = plm_pkg::COUNT_W;
  localparam int PW = plm_pkg::PEAK_W;

  logic          en;
  logic          issue;
  logic          head_last;
  logic [IW-1:0] idx;

  // stage valids, stage 7 is the output register
  logic [7:1] vld;

  logic [2:0]  fmt_p  [1:6];
  logic [2:0]  ch_p   [1:6];
  logic        last_p [1:6];
  logic        neg_p  [3:6];

  logic [PW-1:0] p1;
  logic [34:0]   x2;
  logic [33:0]   m3;
  logic [48:0]   a4;
  logic [16:0]   q5;
  logic [32:0]   s5;
  logic [16:0]   q6;
  logic [32:0]   s6;

  logic [5:0]  k2, k4, k5, k6;
  logic [34:0] mabs;
  logic [33:0] m_lim;
  logic [16:0] f5_hi, f6_hi, f7_hi;
  logic [31:0] f5_lo, f6_lo, f7_lo;
  logic [32:0] s7;
  logic [16:0] qf;
  logic signed [15:0] lvl;

  assign en        = !(vld[7] && level_stall);
  assign issue     = en && head_ctrl.valid;
  assign head_last = (CW'(idx) + CW'(1)) == head_ctrl.count;
  assign pop       = issue && head_last;

  assign level_valid = vld[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (pop) begin
      idx <= '0;
    end else if (issue) begin
      idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:1], issue};
    end
  end

  assign k2 = plm_pkg::fmt_bits(fmt_p[2]);
  assign k4 = plm_pkg::fmt_bits(fmt_p[4]);
  assign k5 = plm_pkg::fmt_bits(fmt_p[5]);
  assign k6 = plm_pkg::fmt_bits(fmt_p[6]);

  // magnitude, clipped at 2^(k+1) where the level is saturated anyway
  always_comb begin
    mabs  = x2[34] ? -x2 : x2;
    m_lim = 34'(1) << (k2 + 6'd1);
  end

  // fold by 2^k - 1: n = hi*2^k + lo, so n / (2^k-1) = hi + (hi+lo) / (2^k-1)
  always_comb begin
    f5_hi = 17'(a4 >> k4);
    f5_lo = 32'(a4 & ((49'(1) << k4) - 49'(1)));
    f6_hi = 17'(s5 >> k5);
    f6_lo = 32'(s5 & ((33'(1) << k5) - 33'(1)));
    f7_hi = 17'(s6 >> k6);
    f7_lo = 32'(s6 & ((33'(1) << k6) - 33'(1)));
    s7    = 33'(f7_hi) + 33'(f7_lo);
    qf    = q6 + f7_hi + 17'(s7 >= plm_pkg::fmt_max(fmt_p[6]));
  end

  // sign and saturation
  always_comb begin
    if (!plm_pkg::fmt_known(fmt_p[6])) begin
      lvl = '0;
    end else if (neg_p[6]) begin
      lvl = (qf > 17'd32768) ? -16'sd32768 : 16'(-qf);
    end else begin
      lvl = (qf > 17'd32767) ? 16'sd32767 : 16'(qf);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: pick the channel's peak
      p1        <= head_peaks[idx];
      fmt_p[1]  <= head_ctrl.fmt;
      ch_p[1]   <= 3'(idx);
      last_p[1] <= head_last;
      for (int i = 2; i <= 6; i++) begin
        fmt_p[i]  <= fmt_p[i-1];
        ch_p[i]   <= ch_p[i-1];
        last_p[i] <= last_p[i-1];
      end
      for (int i = 4; i <= 6; i++) begin
        neg_p[i] <= neg_p[i-1];
      end
      // stage 2: signed peak or 2*peak - full scale
      if (plm_pkg::fmt_signed(fmt_p[1])) begin
        x2 <= {{2{p1[PW-1]}}, p1};
      end else begin
        x2 <= {p1[PW-1], p1, 1'b0} - {2'b00, plm_pkg::fmt_max(fmt_p[1])};
      end
      // stage 3: magnitude and sign
      neg_p[3] <= x2[34];
      m3       <= (34'(mabs) > m_lim) ? m_lim : 34'(mabs);
      // stage 4: times 32767 as shift and subtract
      a4 <= {m3, 15'd0} - 49'(m3);
      // stages 5 to 7: three folds and a final compare
      q5 <= f5_hi;
      s5 <= 33'(f5_hi) + 33'(f5_lo);
      q6 <= q5 + f6_hi;
      s6 <= 33'(f6_hi) + 33'(f6_lo);
      level_word.channel    <= ch_p[6];
      level_word.level      <= lvl;
      level_word.last_level <= last_p[6];
    end
  end

  `ASSERT_IMPL(a_idx_in_range, clk, rst, head_ctrl.valid, (CW'(idx) < head_ctrl.count), "channel index past snapshot count")
  `ASSERT_NEXT(a_idx_restart, clk, rst, pop, (idx == '0), "channel walk did not restart after pop")

endmodule

`default_nettype wire

// File: design/pcm_channel_peak_level_meter_top.sv
// ----------------------------------------------------------------------------
// pcm_channel_peak_level_meter_top
// per-channel peak meter for interleaved pcm, one q1.15 level per channel
// at every buffer end
// ----------------------------------------------------------------------------
//
//   port group   dir   handshake                  word
//   ----------   ---   ------------------------   -----------------------------
//   sample_*     in    sample_valid/sample_stall  sample, last_in_buffer
//   level_*      out   level_valid/level_stall    channel, level, last_level
//   cfg_*        in    cfg_we (no back-pressure)  register index and value
//
// one sample word is taken per cycle while the queue is not full; the peak
// compare-and-replace for the current channel is registered in the front
// a buffer end copies all peaks into a two-deep snapshot queue, the level
// unit then gives one level word per cycle while level_stall is low, n
// words per buffer, passed through the pipeline to the output register
// sample_stall rises only while the snapshot queue holds two buffers
// synchronous reset clears peaks, cursor and queue, no sweep
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcm_channel_peak_level_meter_top #(
  parameter int MAX_CHANNELS = plm_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration writes
  input  wire logic                            cfg_we,
  input  wire logic [plm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [plm_pkg::CFG_DATA_W-1:0]  cfg_data,
  // sample words in
  input  wire logic                            sample_valid,
  output logic                                 sample_stall,
  input  wire plm_pkg::sample_word_t           sample_word,
  // level words out
  output logic                                 level_valid,
  input  wire logic                            level_stall,
  output plm_pkg::level_word_t                 level_word
);

  // snapshot handed from front to queue
  plm_pkg::snap_ctrl_t                            push_ctrl;
  logic [MAX_CHANNELS-1:0][plm_pkg::PEAK_W-1:0]   push_peaks;
  logic                                           q_full;

  // oldest pending snapshot
  plm_pkg::snap_ctrl_t                            head_ctrl;
  logic [MAX_CHANNELS-1:0][plm_pkg::PEAK_W-1:0]   head_peaks;
  logic                                           pop;

  // front: registers, decode, rotation and peak hold
  plm_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_word  (sample_word),
    .q_full       (q_full),
    .push_ctrl    (push_ctrl),
    .push_peaks   (push_peaks)
  );

  // queue: lets the next buffer run while levels drain
  plm_queue #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_ctrl  (push_ctrl),
    .push_peaks (push_peaks),
    .full       (q_full),
    .head_ctrl  (head_ctrl),
    .head_peaks (head_peaks),
    .pop        (pop)
  );

  // back: channel walk and normalising pipeline
  plm_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_ctrl   (head_ctrl),
    .head_peaks  (head_peaks),
    .pop         (pop),
    .level_valid (level_valid),
    .level_stall (level_stall),
    .level_word  (level_word)
  );

endmodule

`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the pcm peak level meter: a directed table covering
// format extremes and corner cases, then random buffers under bursty input and
// output back-pressure, every level word checked against a local model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_CH       = plm_pkg::MAX_CHANNELS_DEF;
  localparam int RAND_WORDS   = 455;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_PHASE   = 2;
  localparam int CYCLE_LIMIT  = 200000;
  localparam longint Q15_FULL = 32767;

  // indexes with no register behind them, and format codes with no meaning
  localparam logic [plm_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [plm_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam logic [2:0] FMT_UNKNOWN_6 = 3'd6;
  localparam logic [2:0] FMT_UNKNOWN_7 = 3'd7;

  typedef enum logic {STEP_CFG, STEP_WORD} step_kind_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  typedef struct {
    step_kind_t            kind;
    logic [1:0]            idx;
    logic [3:0]            val;
    plm_pkg::sample_word_t word;
    bit                    typed;
    logic signed [15:0]    level;   // typed level of the buffer's final word
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [3:0]            cfg_data;
  logic                  sample_valid;
  logic                  sample_stall;
  plm_pkg::sample_word_t sample_word;
  logic                  level_valid;
  logic                  level_stall = 1'b0;
  plm_pkg::level_word_t  level_word;

  // meter model state
  logic [2:0]            meter_fmt;
  logic [3:0]            meter_count;
  longint                chan_peak [MAX_CH];
  int                    chan_cursor;
  plm_pkg::level_word_t  pending_levels[$];

  plan_row_t    plan[$];
  int           fail_count = 0;
  int           burst_left = 0;
  int           cycle_count = 0;

  // receiver side
  logic         hold_req = 1'b0;
  logic         hold_done;
  int           hold_left;
  int           mode_left;
  stall_mode_t  stall_mode;

  pcm_channel_peak_level_meter_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_word  (sample_word),
    .level_valid  (level_valid),
    .level_stall  (level_stall),
    .level_word   (level_word)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // model of the meter
  // --------------------------------------------------------------------------

  function automatic int active_count();
    if (meter_count == 4'd0) return 1;
    if (meter_count > MAX_CH) return MAX_CH;
    return int'(meter_count);
  endfunction

  // raw bits to the value the format gives them
  function automatic longint unpack_sample(input logic [2:0] f, input logic [31:0] raw);
    case (f)
      plm_pkg::FMT_S8:  return longint'($signed(raw[7:0]));
      plm_pkg::FMT_S16: return longint'($signed(raw[15:0]));
      plm_pkg::FMT_S32: return longint'($signed(raw));
      plm_pkg::FMT_U8:  return longint'({56'd0, raw[7:0]});
      plm_pkg::FMT_U16: return longint'({48'd0, raw[15:0]});
      default:          return longint'({32'd0, raw});
    endcase
  endfunction

  function automatic logic signed [15:0] scale_peak(input logic [2:0] f, input longint pk);
    longint full;
    longint num;
    longint q;
    case (f)
      plm_pkg::FMT_S8:  full = 127;
      plm_pkg::FMT_S16: full = 32767;
      plm_pkg::FMT_S32: full = 64'd2147483647;
      plm_pkg::FMT_U8:  full = 255;
      plm_pkg::FMT_U16: full = 65535;
      plm_pkg::FMT_U32: full = 64'd4294967295;
      default: return 16'sd0;
    endcase
    if (f == plm_pkg::FMT_S8 || f == plm_pkg::FMT_S16 || f == plm_pkg::FMT_S32)
      num = pk * Q15_FULL;
    else
      num = (2 * pk - full) * Q15_FULL;
    q = num / full;    // truncates toward zero
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // one accepted word; returns how many level words it releases
  function automatic int take_sample(input plm_pkg::sample_word_t w);
    int                   n;
    int                   ch;
    longint               v;
    longint               held;
    plm_pkg::level_word_t lw;
    n    = active_count();
    ch   = chan_cursor;
    v    = unpack_sample(meter_fmt, w.sample);
    held = chan_peak[ch];
    if ((v < 0 ? -v : v) > (held < 0 ? -held : held))
      chan_peak[ch] = v;
    if (!w.last_in_buffer) begin
      chan_cursor = (ch + 1 >= n) ? 0 : ch + 1;
      return 0;
    end
    for (int i = 0; i < n; i++) begin
      lw.channel    = 3'(i);
      lw.level      = scale_peak(meter_fmt, chan_peak[i]);
      lw.last_level = (i + 1 == n);
      pending_levels.push_back(lw);
    end
    for (int i = 0; i < MAX_CH; i++)
      chan_peak[i] = 0;
    chan_cursor = 0;
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // driving
  // --------------------------------------------------------------------------

  // offer one sample word in bursts, returns once it has been taken
  task automatic offer_word(input plm_pkg::sample_word_t w, output int produced);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        sample_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    sample_valid <= 1'b1;
    sample_word  <= w;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    produced = take_sample(w);
  endtask

  // stop offering, let every pending level word out and the pipe go quiet
  task automatic settle();
    sample_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      plm_pkg::CFG_SAMPLE_FORMAT: meter_fmt = val[2:0];
      plm_pkg::CFG_CHANNEL_COUNT: meter_count = val;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 11))
      0: r[7:0]  = 8'h80;
      1: r[7:0]  = 8'h7F;
      2: r[15:0] = 16'h8000;
      3: r[15:0] = 16'h7FFF;
      4: r = 32'h8000_0000;
      5: r = 32'h7FFF_FFFF;
      6: r = 32'hFFFF_FFFF;
      7: r = '0;
      8: r = 32'($urandom_range(0, 15));
      9: r = ~32'($urandom_range(0, 15));
      default: ;
    endcase
    return r;
  endfunction

  function automatic void row_cfg(input logic [1:0] idx, input logic [3:0] val);
    plan_row_t r;
    r.kind  = STEP_CFG;
    r.idx   = idx;
    r.val   = val;
    r.word  = '0;
    r.typed = 1'b0;
    r.level = '0;
    plan.push_back(r);
  endfunction

  function automatic void row_word(input logic [31:0] s, input bit last, input bit typed,
                                   input int lvl);
    plan_row_t r;
    r.kind                = STEP_WORD;
    r.idx                 = '0;
    r.val                 = '0;
    r.word.sample         = s;
    r.word.last_in_buffer = last;
    r.typed               = typed;
    r.level               = 16'(lvl);
    plan.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // receiver: own stall pattern, plus one long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      level_stall <= 1'b0;
      stall_mode  <= STALL_NONE;
      mode_left   <= 0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (hold_left != 0) begin
      level_stall <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      level_stall <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(8, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:   level_stall <= 1'b0;
        STALL_LIGHT:  level_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  level_stall <= ($urandom_range(0, 3) != 0);
        STALL_TOGGLE: level_stall <= ~level_stall;
        default:      level_stall <= 1'b0;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // level word checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_levels
    plm_pkg::level_word_t due;
    if (!rst && level_valid && !level_stall) begin
      if (pending_levels.size() == 0) begin
        $error("unexpected level word: channel %0d level %0d last_level %0b",
               level_word.channel, level_word.level, level_word.last_level);
        fail_count++;
      end else begin
        due = pending_levels.pop_front();
        if (level_word.channel !== due.channel) begin
          $error("channel mismatch: expected %0d, got %0d", due.channel, level_word.channel);
          fail_count++;
        end
        if (level_word.level !== due.level) begin
          $error("level mismatch: expected %0d, got %0d", due.level, level_word.level);
          fail_count++;
        end
        if (level_word.last_level !== due.last_level) begin
          $error("last_level mismatch: expected %0b, got %0b",
                 due.last_level, level_word.last_level);
          fail_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pcm_channel_peak_level_meter_top verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    plm_pkg::sample_word_t w;
    int           produced;
    int           rand_words;
    int           phase;
    int           nbuf;
    int           n;
    int           shape;
    int           len;
    int           code;
    bit           open_end;
    logic [2:0]   fmt_val;
    logic [3:0]   count_val;

    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    sample_valid <= 1'b0;
    sample_word  <= '0;
    meter_fmt   = plm_pkg::FMT_RESET;
    meter_count = plm_pkg::COUNT_RESET;
    chan_cursor = 0;
    for (int i = 0; i < MAX_CH; i++)
      chan_peak[i] = 0;

    // directed table; typed levels are those readable straight off the format
    row_word(32'h0000_7FFF, 1'b0, 1'b0, 0);
    row_word(32'hFFFF_8000, 1'b1, 1'b1, -32768);      // most negative s16 gives the most negative level
    row_cfg(plm_pkg::CFG_CHANNEL_COUNT, 4'd1);
    row_cfg(plm_pkg::CFG_SAMPLE_FORMAT, {1'b0, plm_pkg::FMT_S8});
    row_word(32'h0000_0080, 1'b1, 1'b1, -32768);
    row_word(32'hFFFF_FF7F, 1'b1, 1'b1, 32767);
    row_cfg(plm_pkg::CFG_SAMPLE_FORMAT, {1'b0, plm_pkg::FMT_S32});
    row_word(32'h8000_0000, 1'b1, 1'b1, -32767);      // truncates toward zero
    row_word(32'h7FFF_FFFF, 1'b1, 1'b1, 32767);
    row_cfg(plm_pkg::CFG_SAMPLE_FORMAT, {1'b0, plm_pkg::FMT_U8});
    row_word(32'hFFFF_FF00, 1'b1, 1'b1, -32767);
    row_word(32'h0000_00FF, 1'b1, 1'b1, 32767);
    row_cfg(plm_pkg::CFG_SAMPLE_FORMAT, {1'b0, plm_pkg::FMT_U16});
    row_word(32'h0001_FFFF, 1'b1, 1'b1, 32767);
    row_cfg(plm_pkg::CFG_SAMPLE_FORMAT, {1'b0, plm_pkg::FMT_U32});
    row_word(32'hFFFF_FFFF, 1'b1, 1'b1, 32767);
    row_word(32'h0000_0000, 1'b1, 1'b1, -32767);
    // unknown formats report zero; bit 3 of the write is dropped
    row_cfg(plm_pkg::CFG_SAMPLE_FORMAT, {1'b0, FMT_UNKNOWN_6});
    row_word(32'hDEAD_BEEF, 1'b1, 1'b1, 0);
    row_cfg(plm_pkg::CFG_SAMPLE_FORMAT, {1'b1, FMT_UNKNOWN_7});
    row_word(32'h1234_5678, 1'b1, 1'b1, 0);
    // writes to spare indexes change nothing
    row_cfg(CFG_SPARE_2, 4'hA);
    row_cfg(CFG_SPARE_3, 4'h5);
    row_cfg(plm_pkg::CFG_SAMPLE_FORMAT, {1'b0, plm_pkg::FMT_S16});
    row_cfg(plm_pkg::CFG_CHANNEL_COUNT, 4'd0);        // zero channels acts as one
    row_word(32'hFFFF_1234, 1'b1, 1'b1, 4660);
    // equal magnitude keeps the first peak
    row_word(32'h0000_8001, 1'b0, 1'b0, 0);
    row_word(32'h0000_7FFF, 1'b1, 1'b1, -32767);
    // count above the maximum clamps; partial frame, idle channels read zero
    row_cfg(plm_pkg::CFG_CHANNEL_COUNT, 4'd15);
    row_word(32'h0000_4000, 1'b0, 1'b0, 0);
    row_word(32'h0000_C000, 1'b0, 1'b0, 0);
    row_word(32'h0000_0001, 1'b1, 1'b1, 0);
    // count lowered under the cursor mid-buffer
    row_cfg(plm_pkg::CFG_CHANNEL_COUNT, 4'd3);
    row_word(32'h0000_0100, 1'b0, 1'b0, 0);
    row_word(32'h0000_0200, 1'b0, 1'b0, 0);
    row_cfg(plm_pkg::CFG_CHANNEL_COUNT, 4'd1);
    row_word(32'h0000_0300, 1'b0, 1'b0, 0);
    row_word(32'h0000_0050, 1'b1, 1'b0, 0);
    // format changed mid-buffer, stored peak converted with the new one
    row_cfg(plm_pkg::CFG_SAMPLE_FORMAT, {1'b0, plm_pkg::FMT_S8});
    row_word(32'h0000_0080, 1'b0, 1'b0, 0);
    row_cfg(plm_pkg::CFG_SAMPLE_FORMAT, {1'b0, plm_pkg::FMT_U8});
    row_word(32'h0000_0010, 1'b1, 1'b0, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        offer_word(plan[i].word, produced);
        if (plan[i].typed && produced != 0)
          pending_levels[pending_levels.size() - 1].level = plan[i].level;
      end
    end

    // random phases: new settings, then a few buffers, mostly whole frames
    rand_words = 0;
    phase      = 0;
    while (rand_words < RAND_WORDS) begin
      settle();
      if ($urandom_range(0, 3) != 0) begin
        code = $urandom_range(0, 9);
        if (code == 8) fmt_val = FMT_UNKNOWN_6;
        else if (code == 9) fmt_val = FMT_UNKNOWN_7;
        else fmt_val = 3'(code % 6);
        write_reg(plm_pkg::CFG_SAMPLE_FORMAT, {1'($urandom_range(0, 1)), fmt_val});
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       count_val = 4'd0;
          1:       count_val = 4'($urandom_range(9, 15));
          2:       count_val = 4'd8;
          3:       count_val = 4'd1;
          default: count_val = 4'($urandom_range(1, 8));
        endcase
        write_reg(plm_pkg::CFG_CHANNEL_COUNT, count_val);
      end
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, 4'($urandom()));

      // one phase runs into a long output hold-off so the snapshot queue fills
      if (phase == HOLD_PHASE) hold_req <= 1'b1;
      nbuf = (phase == HOLD_PHASE) ? 10 : $urandom_range(1, 5);

      for (int b = 0; b < nbuf; b++) begin
        n     = active_count();
        shape = $urandom_range(0, 9);
        if (phase == HOLD_PHASE) len = $urandom_range(1, 3);
        else if (shape < 6) len = n * $urandom_range(1, 4);
        else if (shape < 9) len = $urandom_range(1, 4 * n);
        else len = $urandom_range(1, 40);
        // an unterminated buffer leaves the next settings to land mid-buffer
        open_end = (shape == 9) && (b == nbuf - 1) && (phase != HOLD_PHASE);
        for (int j = 0; j < len && rand_words < RAND_WORDS; j++) begin
          w.sample         = pick_sample();
          w.last_in_buffer = ((j == len - 1) && !open_end) || ($urandom_range(0, 31) == 0);
          offer_word(w, produced);
          rand_words++;
        end
      end
      phase++;
    end

    settle();
    if (fail_count == 0 && pending_levels.size() == 0) begin
      $display("pcm_channel_peak_level_meter_top verification clean");
    end else begin
      $display("pcm_channel_peak_level_meter_top verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/plm_pkg.sv
design/plm_front.sv
design/plm_queue.sv
design/plm_back.sv
design/pcm_channel_peak_level_meter_top.sv
test/tb_top.sv
